/* sv/sok_pkg.sv */
// shared constants and types for the string order key core
package sok_pkg;

  localparam int unsigned MaxLengthDefault = 4096;
  localparam int unsigned LEN_W            = 13;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned SUM_W            = 20;
  localparam int unsigned KEY_W            = 32;
  localparam int unsigned LOG_W            = 4;
  localparam int unsigned SHIFT_W          = 5;
  localparam logic [LOG_W-1:0] LOG_MAX     = LOG_W'(12);
  localparam logic [SHIFT_W-1:0] LEN_TOP   = SHIFT_W'(28);
  localparam logic [SHIFT_W-1:0] SUM_TOP   = SHIFT_W'(20);
  localparam logic [LEN_W-1:0] CUT_255     = LEN_W'(255);
  localparam logic [LEN_W-1:0] CUT_511     = LEN_W'(511);
  localparam logic [LEN_W-1:0] CUT_1023    = LEN_W'(1023);
  localparam logic [BYTE_W-1:0] UPPER_A    = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_Z    = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_BIT   = 8'h20;

  // string state handed to the key packer
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] first_byte;
    logic [SUM_W-1:0]  running_sum;
    logic [SUM_W-1:0]  sum_at_255;
    logic [SUM_W-1:0]  sum_at_511;
    logic [SUM_W-1:0]  sum_at_1023;
  } key_src_t;

endpackage

/* sv/sok_key.sv */
// packs length class, length remainder, first byte and prefix sum into the order key
module sok_key (
  input  sok_pkg::key_src_t              src,
  output logic [sok_pkg::KEY_W-1:0]      key
);

  logic [sok_pkg::LOG_W-1:0]   lg;
  logic [sok_pkg::SUM_W-1:0]   sum_sel;
  logic [sok_pkg::LEN_W-1:0]   len_rem;
  logic [sok_pkg::SHIFT_W-1:0] len_sh;
  logic [sok_pkg::SHIFT_W-1:0] sum_sh;
  logic [sok_pkg::KEY_W-1:0]   sum_mask;

  // floor log2 of the length, highest set bit wins
  always_comb begin
    lg = '0;
    for (int i = 0; i < int'(sok_pkg::LEN_W); i++) begin
      if (src.len[i]) begin
        lg = sok_pkg::LOG_W'(i);
      end
    end
    if (lg > sok_pkg::LOG_MAX) begin
      lg = sok_pkg::LOG_MAX;
    end
  end

  // longer strings sum only a prefix, taken from the checkpoints
  always_comb begin
    case (lg)
      4'd12:   sum_sel = src.sum_at_255;
      4'd11:   sum_sel = src.sum_at_511;
      4'd10:   sum_sel = src.sum_at_1023;
      default: sum_sel = src.running_sum;
    endcase
  end

  assign len_rem  = src.len - (sok_pkg::LEN_W'(1) << lg);
  assign len_sh   = sok_pkg::LEN_TOP - sok_pkg::SHIFT_W'(lg);
  assign sum_sh   = sok_pkg::SUM_TOP - sok_pkg::SHIFT_W'(lg);
  assign sum_mask = (sok_pkg::KEY_W'(1) << sum_sh) - sok_pkg::KEY_W'(1);

  always_comb begin
    if (src.len == '0) begin
      key = '0;
    end else begin
      key = {lg + sok_pkg::LOG_W'(1), {(sok_pkg::KEY_W - sok_pkg::LOG_W){1'b0}}}
          | (sok_pkg::KEY_W'(len_rem) << len_sh)
          | (sok_pkg::KEY_W'(src.first_byte) << sum_sh)
          | (sok_pkg::KEY_W'(sum_sel) & sum_mask);
    end
  end

endmodule

/* sv/string_order_key_core.sv */
// string order key core: streams string bytes and emits one packed key per string
//
// input channel: one byte per transaction (in_valid/in_stall), in_last_byte marks
// the end of a string, in_empty_string gives a zero-length string and drops any
// partial one. result channel (out_valid/out_stall) carries one transaction per
// string: the 32-bit key and a too_long flag (key 0 when set).
// cfg_wr_en writes the case mode bit (reset 1); 0 lowers ascii letters after the
// first byte before summing. write it only between strings.
// the result is presented in the cycle after the last byte is taken. throughput:
// one byte per cycle while in_stall is low; the byte count, running sum and
// checkpoint registers are updated once per byte and the key is packed in the
// same cycle. when the receiver stalls with a result held, in_stall is raised
// until that result is taken. reset clears all string state and empties the output register.
module string_order_key_core #(
  parameter int unsigned MAX_LENGTH = sok_pkg::MaxLengthDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sok_pkg::BYTE_W-1:0]    in_byte_value,
  input  logic                          in_last_byte,
  input  logic                          in_empty_string,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sok_pkg::KEY_W-1:0]     out_string_key,
  output logic                          out_too_long
);

  localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);

  logic                        case_sens_r;
  logic [CNT_W-1:0]            byte_count_r, byte_count_nxt;
  logic [sok_pkg::BYTE_W-1:0]  first_byte_r, first_byte_nxt;
  logic [sok_pkg::SUM_W-1:0]   running_sum_r, running_sum_nxt;
  logic [sok_pkg::SUM_W-1:0]   sum_255_r, sum_255_nxt;
  logic [sok_pkg::SUM_W-1:0]   sum_511_r, sum_511_nxt;
  logic [sok_pkg::SUM_W-1:0]   sum_1023_r, sum_1023_nxt;
  logic                        overflow_r, overflow_nxt;
  logic                        out_valid_r;
  logic [sok_pkg::KEY_W-1:0]   out_key_r;
  logic                        out_too_long_r;

  logic                        in_acc;
  logic [sok_pkg::LEN_W-1:0]   idx;
  logic [sok_pkg::BYTE_W-1:0]  sum_byte;
  logic [sok_pkg::SUM_W-1:0]   sum_add;
  sok_pkg::key_src_t           key_src;
  logic [sok_pkg::KEY_W-1:0]   key;

  assign in_stall       = out_valid_r & out_stall;
  assign in_acc         = in_valid & ~in_stall;
  assign out_valid      = out_valid_r;
  assign out_string_key = out_key_r;
  assign out_too_long   = out_too_long_r;

  assign idx = sok_pkg::LEN_W'(byte_count_r);

  // optional ascii lowering for bytes after the first
  always_comb begin
    sum_byte = in_byte_value;
    if (!case_sens_r && in_byte_value >= sok_pkg::UPPER_A
        && in_byte_value <= sok_pkg::UPPER_Z) begin
      sum_byte = in_byte_value + sok_pkg::CASE_BIT;
    end
  end

  assign sum_add = running_sum_r + sok_pkg::SUM_W'(sum_byte);

  always_comb begin
    byte_count_nxt  = byte_count_r;
    first_byte_nxt  = first_byte_r;
    running_sum_nxt = running_sum_r;
    sum_255_nxt     = sum_255_r;
    sum_511_nxt     = sum_511_r;
    sum_1023_nxt    = sum_1023_r;
    overflow_nxt    = overflow_r;
    if (byte_count_r >= CNT_W'(MAX_LENGTH)) begin
      overflow_nxt = 1'b1;
    end else begin
      if (byte_count_r == '0) begin
        first_byte_nxt = in_byte_value;
      end else begin
        running_sum_nxt = sum_add;
        if (idx == sok_pkg::CUT_255) begin
          sum_255_nxt = sum_add;
        end
        if (idx == sok_pkg::CUT_511) begin
          sum_511_nxt = sum_add;
        end
        if (idx == sok_pkg::CUT_1023) begin
          sum_1023_nxt = sum_add;
        end
      end
      byte_count_nxt = byte_count_r + CNT_W'(1);
    end
  end

  assign key_src.len         = sok_pkg::LEN_W'(byte_count_nxt);
  assign key_src.first_byte  = first_byte_nxt;
  assign key_src.running_sum = running_sum_nxt;
  assign key_src.sum_at_255  = sum_255_nxt;
  assign key_src.sum_at_511  = sum_511_nxt;
  assign key_src.sum_at_1023 = sum_1023_nxt;

  sok_key u_key (
    .src (key_src),
    .key (key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_sens_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case_sens_r <= cfg_wr_data;
    end
  end

  // string state, cleared after every result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      first_byte_r  <= '0;
      running_sum_r <= '0;
      sum_255_r     <= '0;
      sum_511_r     <= '0;
      sum_1023_r    <= '0;
      overflow_r    <= 1'b0;
    end else if (in_acc) begin
      if (in_empty_string || in_last_byte) begin
        byte_count_r  <= '0;
        first_byte_r  <= '0;
        running_sum_r <= '0;
        sum_255_r     <= '0;
        sum_511_r     <= '0;
        sum_1023_r    <= '0;
        overflow_r    <= 1'b0;
      end else begin
        byte_count_r  <= byte_count_nxt;
        first_byte_r  <= first_byte_nxt;
        running_sum_r <= running_sum_nxt;
        sum_255_r     <= sum_255_nxt;
        sum_511_r     <= sum_511_nxt;
        sum_1023_r    <= sum_1023_nxt;
        overflow_r    <= overflow_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && (in_empty_string || in_last_byte)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc && (in_empty_string || in_last_byte)) begin
      if (in_empty_string) begin
        out_key_r      <= '0;
        out_too_long_r <= 1'b0;
      end else if (overflow_nxt) begin
        out_key_r      <= '0;
        out_too_long_r <= 1'b1;
      end else begin
        out_key_r      <= key;
        out_too_long_r <= 1'b0;
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// testbench for string_order_key_core: streamed strings checked against a key predictor
module tb_top;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned IDLE_PERCENT   = 15;
  localparam int unsigned MAX_STR_LEN    = sok_pkg::MaxLengthDefault;

  typedef struct packed {
    logic [sok_pkg::KEY_W-1:0] string_key;
    logic                      too_long;
  } key_result_t;

  // predicts the key of every completed string and checks the result transactions
  class key_scoreboard;
    bit                         raw_mode;
    logic [sok_pkg::LEN_W-1:0]  byte_count;
    logic [sok_pkg::BYTE_W-1:0] first_byte;
    logic [sok_pkg::SUM_W-1:0]  running_sum;
    logic [sok_pkg::SUM_W-1:0]  sum_at_255;
    logic [sok_pkg::SUM_W-1:0]  sum_at_511;
    logic [sok_pkg::SUM_W-1:0]  sum_at_1023;
    bit                         overflow_seen;
    key_result_t                expected_keys[$];
    int unsigned                mismatches;

    function new();
      raw_mode = 1'b1;
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      byte_count    = '0;
      first_byte    = '0;
      running_sum   = '0;
      sum_at_255    = '0;
      sum_at_511    = '0;
      sum_at_1023   = '0;
      overflow_seen = 1'b0;
    endfunction

    function void set_case_mode(bit v);
      raw_mode = v;
    endfunction

    function int unsigned pending();
      return expected_keys.size();
    endfunction

    function logic [sok_pkg::KEY_W-1:0] pack_key();
      int unsigned len;
      int unsigned lg;
      int unsigned dbits;
      int unsigned sum_sel;
      len = byte_count;
      lg = $clog2(len + 1) - 1;
      if (lg > 12) lg = 12;
      case (lg)
        12:      sum_sel = sum_at_255;
        11:      sum_sel = sum_at_511;
        10:      sum_sel = sum_at_1023;
        default: sum_sel = running_sum;
      endcase
      dbits = sok_pkg::SUM_TOP - lg;
      return ((lg + 1) << sok_pkg::LEN_TOP)
           | ((len - (32'd1 << lg)) << (sok_pkg::LEN_TOP - lg))
           | (int'(first_byte) << dbits)
           | (sum_sel & ((32'd1 << dbits) - 1));
    endfunction

    function void note_byte(logic [sok_pkg::BYTE_W-1:0] b, bit is_last, bit is_empty);
      logic [sok_pkg::BYTE_W-1:0] v;
      key_result_t r;
      if (is_empty) begin
        // a zero-length string drops whatever was partly received
        clear_string();
        r.string_key = '0;
        r.too_long = 1'b0;
        expected_keys.push_back(r);
        return;
      end
      if (byte_count >= MAX_STR_LEN) begin
        overflow_seen = 1'b1;
      end else begin
        if (byte_count == 0) begin
          first_byte = b;
        end else begin
          v = b;
          if (!raw_mode && b >= sok_pkg::UPPER_A && b <= sok_pkg::UPPER_Z)
            v = b + sok_pkg::CASE_BIT;
          running_sum = running_sum + sok_pkg::SUM_W'(v);
          if (byte_count == sok_pkg::CUT_255) sum_at_255 = running_sum;
          if (byte_count == sok_pkg::CUT_511) sum_at_511 = running_sum;
          if (byte_count == sok_pkg::CUT_1023) sum_at_1023 = running_sum;
        end
        byte_count = byte_count + 1'b1;
      end
      if (!is_last) return;
      if (overflow_seen) begin
        r.string_key = '0;
        r.too_long = 1'b1;
      end else begin
        r.string_key = pack_key();
        r.too_long = 1'b0;
      end
      expected_keys.push_back(r);
      clear_string();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [sok_pkg::KEY_W-1:0] got_key, logic got_too_long);
      key_result_t want;
      if (expected_keys.size() == 0) begin
        report_mismatch($sformatf("key %h with no string pending", got_key));
        return;
      end
      want = expected_keys.pop_front();
      if (got_key !== want.string_key)
        report_mismatch($sformatf("string_key %h, predicted %h", got_key, want.string_key));
      if (got_too_long !== want.too_long)
        report_mismatch($sformatf("too_long %b, predicted %b", got_too_long, want.too_long));
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic                         cfg_wr_data;
  logic                         in_valid;
  logic                         in_stall;
  logic [sok_pkg::BYTE_W-1:0]   in_byte_value;
  logic                         in_last_byte;
  logic                         in_empty_string;
  logic                         out_valid;
  logic                         out_stall;
  logic [sok_pkg::KEY_W-1:0]    out_string_key;
  logic                         out_too_long;

  key_scoreboard sb = new();
  bit            quiet_mode;
  bit            hold_req;
  int unsigned   bytes_sent;

  string_order_key_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .in_last_byte    (in_last_byte),
    .in_empty_string (in_empty_string),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_string_key  (out_string_key),
    .out_too_long    (out_too_long)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

  // both transactions are sampled at the edge where they complete
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_byte_value, in_last_byte, in_empty_string);
      if (out_valid && !out_stall) sb.check_result(out_string_key, out_too_long);
    end
  end

  // receiver: random stalls, none in quiet mode, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet_mode) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  function automatic logic [sok_pkg::BYTE_W-1:0] rand_byte();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      return sok_pkg::BYTE_W'($urandom_range(sok_pkg::UPPER_A, sok_pkg::UPPER_Z));
    if (pick < 40)
      return sok_pkg::BYTE_W'($urandom_range(sok_pkg::UPPER_A, sok_pkg::UPPER_Z))
             | sok_pkg::CASE_BIT;
    if (pick < 45) return 8'h00;
    if (pick < 50) return 8'hFF;
    return sok_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(logic [sok_pkg::BYTE_W-1:0] b, bit is_last, bit is_empty);
    if (!quiet_mode && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte_value   <= b;
    in_last_byte    <= is_last;
    in_empty_string <= is_empty;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_string(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(rand_byte(), i == len - 1, 1'b0);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1, 1'b0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_case_mode(bit v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_case_mode(v);
  endtask

  task automatic random_strings(int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_byte(sok_pkg::BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end else if (pick < 10) begin
        // abandoned string, cut short by an empty one
        repeat ($urandom_range(1, 6)) send_byte(rand_byte(), 1'b0, 1'b0);
        send_byte(rand_byte(), 1'($urandom_range(0, 1)), 1'b1);
      end else if (pick < 85) begin
        send_string($urandom_range(1, 24));
      end else begin
        send_string($urandom_range(25, 300));
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= 1'b0;
    in_valid        <= 1'b0;
    in_byte_value   <= '0;
    in_last_byte    <= 1'b0;
    in_empty_string <= 1'b0;
    quiet_mode = 1'b0;
    hold_req = 1'b0;
    bytes_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // raw bytes under the reset mode
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hAB, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b1, 1'b1);
    send_text("AZ@[");
    send_byte(8'h61, 1'b0, 1'b0);
    send_byte(8'h62, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_text("aZ");

    // letters at and around the case range, first byte kept raw
    write_case_mode(1'b0);
    send_text("QAZ@[`az{");
    send_text("Mm");
    send_byte(8'hFF, 1'b1, 1'b0);

    random_strings(120);

    write_case_mode(1'b1);
    quiet_mode = 1'b1;
    random_strings(120);
    drain_results();
    quiet_mode = 1'b0;

    // receiver holds off while strings keep coming
    hold_req = 1'b1;
    random_strings(100);

    // a string long enough to pass the first sum checkpoint
    write_case_mode(1'b0);
    send_string(260);

    random_strings(60);
    drain_results();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
